// File: hdl/clf_pkg.sv
// Shared types, codes and sizing constants for the cine loop frame index controller.
`default_nettype none

package clf_pkg;

  // Default frame memory depth and the fixed number of areas
  localparam int FRAME_SLOTS_DEF = 256;
  localparam int AREA_NUM        = 4;

  // Action codes
  localparam logic [3:0] ACT_ADD       = 4'd0;
  localparam logic [3:0] ACT_FWD       = 4'd1;
  localparam logic [3:0] ACT_BWD       = 4'd2;
  localparam logic [3:0] ACT_TRIM_L    = 4'd3;
  localparam logic [3:0] ACT_TRIM_R    = 4'd4;
  localparam logic [3:0] ACT_TRIM_RST  = 4'd5;
  localparam logic [3:0] ACT_PREPARE   = 4'd6;
  localparam logic [3:0] ACT_SELECT    = 4'd7;
  localparam logic [3:0] ACT_CLR_CUR   = 4'd8;
  localparam logic [3:0] ACT_CLR_ALL   = 4'd9;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Area split codes of the mode register
  localparam logic [1:0] MODE_ONE  = 2'd0;
  localparam logic [1:0] MODE_TWO  = 2'd1;
  localparam logic [1:0] MODE_FOUR = 2'd2;

  typedef struct packed {
    logic [3:0] action;
    logic [1:0] area;
    logic       clear_area;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot;
    logic [7:0] play_position;
    logic [8:0] frame_count;
    logic [7:0] trim_left;
    logic [7:0] trim_right;
    logic [8:0] window_length;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic apply;
    logic rem_start;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rem_busy;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hdl/cine_loop_frame_index_controller.sv
// Top level of the cine loop frame index controller.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall    in_beat  (action, area, clear_area)
//   out_     output     out_valid / out_stall  out_beat (status .. window_length)
//   cfg_     input      cfg_we                 cfg_wdata (area_mode)
//
// One action at a time: accept, a load step, a run of the shared remainder unit that maps
// the play index onto the ring, and a result step; the unit works on SUM_W-bit values,
// SUM_W = clog2(2 * FRAME_SLOTS + 256).
// The next beat is taken while the previous result still waits in the output register.
// A stalled result holds the controller in its last state until the register frees.
// Reset (rst_n low, synchronous) empties every area, zeroes the trims and selects area 0.
`default_nettype none

module cine_loop_frame_index_controller #(
  parameter int FRAME_SLOTS = clf_pkg::FRAME_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire clf_pkg::in_beat_t  in_beat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output clf_pkg::out_beat_t      out_beat,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata
);
  import clf_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequence each action
  clf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the ring state and build results
  clf_dp #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_beat   (in_beat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

endmodule

`default_nettype wire

// File: hdl/clf_rem.sv
// Iterative remainder unit: one restoring shift-subtract step per cycle.
`default_nettype none

module clf_rem #(
  parameter int SUM_W = 10,
  parameter int DIV_W = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  busy,
  output logic [SUM_W-1:0]      remainder
);

  localparam int CW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] q_r,   q_nxt;
  logic [SUM_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] d_r,   d_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   d_ext;

  assign busy      = (cnt_r != '0);
  assign remainder = rem_r[SUM_W-1:0];

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial   = {rem_r[SUM_W-1:0], q_r[SUM_W-1]};
    d_ext   = (SUM_W+1)'(d_r);
    q_nxt   = q_r;
    rem_nxt = rem_r;
    d_nxt   = d_r;
    cnt_nxt = cnt_r;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      d_nxt   = divisor;
      cnt_nxt = CW'(SUM_W);
    end else if (busy) begin
      q_nxt   = {q_r[SUM_W-2:0], 1'b0};
      rem_nxt = (trial >= d_ext) ? (trial - d_ext) : trial;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/clf_dp.sv
// Datapath: per-area ring bookkeeping, trim window, slot math and result register.
`default_nettype none

module clf_dp #(
  parameter int FRAME_SLOTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire clf_pkg::ctrl_cmd_t cmd,
  output clf_pkg::dp_sts_t       sts,
  input  wire clf_pkg::in_beat_t in_beat,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output clf_pkg::out_beat_t     out_beat
);
  import clf_pkg::*;

  localparam int CNT_W    = $clog2(FRAME_SLOTS + 1);
  localparam int OFS_W    = $clog2(FRAME_SLOTS);
  localparam int SUM_W    = $clog2(2 * FRAME_SLOTS + 256);
  localparam int CAP_ONE  = FRAME_SLOTS;
  localparam int CAP_TWO  = FRAME_SLOTS / 2;
  localparam int CAP_FOUR = FRAME_SLOTS / 4;

  // Area is inside the configured split
  function automatic logic area_ok(logic [1:0] mode, logic [1:0] a);
    logic ok;
    ok = 1'b0;
    unique case (mode)
      MODE_ONE:  ok = (a == 2'd0);
      MODE_TWO:  ok = !a[1];
      MODE_FOUR: ok = 1'b1;
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Ring capacity of one area, zero outside the split
  function automatic logic [CNT_W-1:0] cap_of(logic [1:0] mode, logic [1:0] a);
    logic [CNT_W-1:0] c;
    c = '0;
    if (area_ok(mode, a)) begin
      unique case (mode)
        MODE_ONE:  c = CNT_W'(CAP_ONE);
        MODE_TWO:  c = CNT_W'(CAP_TWO);
        MODE_FOUR: c = CNT_W'(CAP_FOUR);
        default:   c = '0;
      endcase
    end
    return c;
  endfunction

  // First physical slot of an area
  function automatic logic [SUM_W-1:0] base_of(logic [CNT_W-1:0] cap, logic [1:0] a);
    logic [SUM_W-1:0] cx;
    logic [SUM_W-1:0] b;
    cx = SUM_W'(cap);
    b  = '0;
    unique case (a)
      2'd0:    b = '0;
      2'd1:    b = cx;
      2'd2:    b = cx << 1;
      2'd3:    b = (cx << 1) + cx;
      default: b = '0;
    endcase
    return b;
  endfunction

  logic [1:0]       mode_r,   mode_nxt;
  logic [1:0]       cur_r,    cur_nxt;
  logic [CNT_W-1:0] held_r   [AREA_NUM];
  logic [CNT_W-1:0] held_nxt [AREA_NUM];
  logic [OFS_W-1:0] old_r    [AREA_NUM];
  logic [OFS_W-1:0] old_nxt  [AREA_NUM];
  logic [7:0]       play_r   [AREA_NUM];
  logic [7:0]       play_nxt [AREA_NUM];
  logic [7:0]       wf_r,     wf_nxt;
  logic [7:0]       wl_r,     wl_nxt;
  logic             wrote_r,  wrote_nxt;
  logic             reject_r, reject_nxt;
  logic [7:0]       add_slot_r, add_slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_beat_r, out_beat_nxt;

  logic [1:0]       a;
  logic [CNT_W-1:0] n;
  logic [OFS_W-1:0] old;
  logic [7:0]       play;
  logic [CNT_W-1:0] cap;
  logic             n_nz;
  logic             cap_nz;
  logic [SUM_W-1:0] n_ext;
  logic [SUM_W-1:0] n_m1;
  logic [SUM_W-1:0] cap_ext;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] sum_add;
  logic [SUM_W-1:0] wrap_add;
  logic [SUM_W-1:0] add_pos;
  logic [OFS_W-1:0] old_inc;
  logic [7:0]       wl_fresh;
  logic [SUM_W-1:0] rem_div;
  logic [SUM_W-1:0] rem_val;
  logic             rem_busy;
  logic [SUM_W-1:0] slot_calc;

  // Look at the current area
  always_comb begin
    a        = cur_r;
    n        = held_r[a];
    old      = old_r[a];
    play     = play_r[a];
    cap      = cap_of(mode_r, a);
    n_nz     = (n != '0);
    cap_nz   = (cap != '0);
    n_ext    = SUM_W'(n);
    n_m1     = n_ext - 1'b1;
    cap_ext  = SUM_W'(cap);
    base     = base_of(cap, a);
    sum_add  = SUM_W'(old) + n_ext;
    wrap_add = (sum_add >= cap_ext) ? (sum_add - cap_ext) : sum_add;
    add_pos  = base + ((n < cap) ? wrap_add : SUM_W'(old));
    old_inc  = ((SUM_W'(old) + 1'b1) == cap_ext) ? '0 : (old + 1'b1);
    wl_fresh = n_nz ? n_m1[7:0] : 8'd0;
    rem_div  = SUM_W'(old) + SUM_W'(play);
  end

  // Apply a register write or one action to the bookkeeping
  always_comb begin
    mode_nxt     = mode_r;
    cur_nxt      = cur_r;
    held_nxt     = held_r;
    old_nxt      = old_r;
    play_nxt     = play_r;
    wf_nxt       = wf_r;
    wl_nxt       = wl_r;
    wrote_nxt    = wrote_r;
    reject_nxt   = reject_r;
    add_slot_nxt = add_slot_r;
    priority if (cfg_we && (cfg_wdata == MODE_ONE || cfg_wdata == MODE_TWO ||
                            cfg_wdata == MODE_FOUR)) begin
      mode_nxt = cfg_wdata;
      cur_nxt  = 2'd0;
      for (int i = 0; i < AREA_NUM; i++) begin
        held_nxt[i] = '0;
        old_nxt[i]  = '0;
        play_nxt[i] = '0;
      end
    end else if (cmd.apply) begin
      wrote_nxt  = 1'b0;
      reject_nxt = 1'b0;
      unique case (in_beat.action)
        ACT_ADD: begin
          if (cap_nz) begin
            wrote_nxt    = 1'b1;
            add_slot_nxt = add_pos[7:0];
            if (n < cap) begin
              held_nxt[a] = n + 1'b1;
            end else begin
              old_nxt[a] = old_inc;
            end
          end
        end
        ACT_FWD: begin
          if (n_nz) begin
            play_nxt[a] = (play < wl_r) ? (play + 8'd1) : wf_r;
          end
        end
        ACT_BWD: begin
          if (n_nz) begin
            play_nxt[a] = (play > wf_r) ? (play - 8'd1) : wl_r;
          end
        end
        ACT_TRIM_L: begin
          if (n_nz) begin
            wf_nxt = play;
          end
        end
        ACT_TRIM_R: begin
          if (n_nz && play > wf_r) begin
            wl_nxt = play;
          end
        end
        ACT_TRIM_RST: begin
          wf_nxt = 8'd0;
          wl_nxt = wl_fresh;
        end
        ACT_PREPARE: begin
          wf_nxt      = 8'd0;
          wl_nxt      = wl_fresh;
          play_nxt[a] = wl_fresh;
        end
        ACT_SELECT: begin
          if (!area_ok(mode_r, in_beat.area)) begin
            reject_nxt = 1'b1;
          end else begin
            cur_nxt = in_beat.area;
            if (in_beat.clear_area) begin
              held_nxt[in_beat.area] = '0;
              old_nxt[in_beat.area]  = '0;
            end
          end
        end
        ACT_CLR_CUR: begin
          held_nxt[a] = '0;
          old_nxt[a]  = '0;
          play_nxt[a] = '0;
          wf_nxt      = 8'd0;
          wl_nxt      = 8'd0;
        end
        ACT_CLR_ALL: begin
          for (int i = 0; i < AREA_NUM; i++) begin
            held_nxt[i] = '0;
            old_nxt[i]  = '0;
            play_nxt[i] = '0;
          end
        end
        default: begin
          wrote_nxt = 1'b0;
        end
      endcase
    end
  end

  // Ring position of the play index, reduced modulo the area capacity
  clf_rem #(
    .SUM_W (SUM_W),
    .DIV_W (CNT_W)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.rem_start),
    .dividend  (rem_div),
    .divisor   (cap),
    .busy      (rem_busy),
    .remainder (rem_val)
  );

  // Build the result beat and hold it until taken
  always_comb begin
    slot_calc = base + rem_val;
    out_beat_nxt = out_beat_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt              = 1'b1;
      out_beat_nxt.status        = reject_r ? ST_REJECT : (n_nz ? ST_OK : ST_EMPTY);
      out_beat_nxt.slot          = wrote_r ? add_slot_r :
                                   ((n_nz && cap_nz) ? slot_calc[7:0] : 8'd0);
      out_beat_nxt.play_position = play;
      out_beat_nxt.frame_count   = n_ext[8:0];
      out_beat_nxt.trim_left     = wf_r;
      out_beat_nxt.trim_right    = wl_r;
      out_beat_nxt.window_length = (wl_r >= wf_r) ?
                                   ({1'b0, wl_r} - {1'b0, wf_r} + 9'd1) : 9'd0;
    end
  end

  assign sts.rem_busy = rem_busy;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_beat     = out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ONE;
      cur_r       <= 2'd0;
      wf_r        <= 8'd0;
      wl_r        <= 8'd0;
      wrote_r     <= 1'b0;
      reject_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AREA_NUM; i++) begin
        held_r[i] <= '0;
        old_r[i]  <= '0;
        play_r[i] <= '0;
      end
    end else begin
      mode_r      <= mode_nxt;
      cur_r       <= cur_nxt;
      wf_r        <= wf_nxt;
      wl_r        <= wl_nxt;
      wrote_r     <= wrote_nxt;
      reject_r    <= reject_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
      old_r       <= old_nxt;
      play_r      <= play_nxt;
    end
  end

  always_ff @(posedge clk) begin
    add_slot_r <= add_slot_nxt;
    out_beat_r <= out_beat_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/clf_ctrl.sv
// Controller: sequences accept, remainder run and result load for one action.
`default_nettype none

module clf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire clf_pkg::dp_sts_t  sts,
  output clf_pkg::ctrl_cmd_t     cmd
);
  import clf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Step through one action
  always_comb begin
    state_nxt     = state_r;
    cmd.apply     = 1'b0;
    cmd.rem_start = 1'b0;
    cmd.out_load  = 1'b0;
    in_stall      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.apply = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.rem_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!sts.rem_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/clf_chk.sv
// Port-level checker for the cine loop frame index controller, bound to the top level.
`default_nettype none

module clf_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire clf_pkg::in_beat_t  in_beat,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire clf_pkg::out_beat_t out_beat,
  input wire logic               cfg_we,
  input wire logic [1:0]         cfg_wdata
);
  import clf_pkg::*;

  // One action in flight: an accepted beat stalls the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // An empty area reports no frames and slot zero
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.status == ST_EMPTY) |->
      (out_beat.frame_count == 9'd0 && out_beat.slot == 8'd0))
    else $error("empty status with frames or slot");

  // Window length follows the trims
  a_window_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_beat.trim_right >= out_beat.trim_left) ?
        (out_beat.window_length ==
         ({1'b0, out_beat.trim_right} - {1'b0, out_beat.trim_left} + 9'd1)) :
        (out_beat.window_length == 9'd0))
    else $error("window length does not match trims");

endmodule

bind cine_loop_frame_index_controller clf_chk u_chk (.*);

`default_nettype wire
